// File: src/record_talk_screen_controller_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the record/talk/screen controller
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RECORD_TALK_SCREEN_CONTROLLER_TOP_ASSERT_SVH
`define RECORD_TALK_SCREEN_CONTROLLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define RTSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtsc assertion failed");
// Next-cycle implication, disabled during reset.
`define RTSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtsc assertion failed");
`else
`define RTSC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define RTSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: src/rtsc_pkg.sv
// ----------------------------------------------------------------------------
// Record/talk/screen controller package
// Phase types, event codes, register map and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package rtsc_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REC_IDLE      = 2'd0,
        REC_RECORDING = 2'd1,
        REC_SENDING   = 2'd2,
        REC_SENT      = 2'd3
    } t_rec_phase;

    typedef enum logic [1:0] {
        TALK_OFF        = 2'd0,
        TALK_CONNECTING = 2'd1,
        TALK_ACTIVE     = 2'd2
    } t_talk_phase;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_ACTIVITY  = 3'd1;
    localparam logic [2:0] OP_START     = 3'd2;
    localparam logic [2:0] OP_STOP_SEND = 3'd3;
    localparam logic [2:0] OP_CANCEL    = 3'd4;
    localparam logic [2:0] OP_RECEIPT   = 3'd5;
    localparam logic [2:0] OP_ERROR     = 3'd6;
    localparam logic [2:0] OP_SET_TALK  = 3'd7;

    localparam logic [1:0] REG_SCREEN_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_SENT_HOLD      = 2'd1;
    localparam logic [1:0] REG_SENDING_TMO    = 2'd2;
    localparam logic [1:0] REG_TALK_READY_TMO = 2'd3;

    localparam logic [TIME_W-1:0] RST_SCREEN_TIMEOUT = 32'd10000;
    localparam logic [TIME_W-1:0] RST_SENT_HOLD      = 32'd1500;
    localparam logic [TIME_W-1:0] RST_SENDING_TMO    = 32'd8000;
    localparam logic [TIME_W-1:0] RST_TALK_READY_TMO = 32'd10000;

endpackage

`default_nettype wire

// File: src/record_talk_screen_controller_top.sv
// ----------------------------------------------------------------------------
// Record/talk/screen controller
// Event-driven state keeper for screen, recording and talk with timeouts.
// ----------------------------------------------------------------------------
// Usage:
// Events enter on the input channel (i_in_valid / o_in_ready) as one word of
// opcode, millisecond timestamp and talk target. Each word produces exactly one
// result word on the output channel (o_out_valid / i_out_ready) carrying the
// acceptance bit, the three states, the change flags and the elapsed time.
// A word is captured in an input register, evaluated against the current state
// by one short combinational pass, and written to the output register while
// the state updates in the same cycle. The result thus passes through the input
// and output registers, and one word per cycle is sustained while the receiver
// does not stall.
// When the receiver stalls, the output register holds its word and the input
// register still takes one more word; after that o_in_ready drops until the
// output drains. Reset (i_rst_n low, synchronous) empties both registers,
// restores the phases (screen on, idle, talk off), clears all timestamps to
// zero and reloads the four timeout registers with their defaults.
// The APB port writes the timeouts; it should be used only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module record_talk_screen_controller_top
    import rtsc_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Event channel
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    input  wire  [2:0]             i_opcode,
    input  wire  [TIME_W-1:0]      i_now_ms,
    input  wire  [1:0]             i_talk_target,
    // Result channel
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    output logic                   o_accepted,
    output logic                   o_screen_on,
    output logic [1:0]             o_rec_state,
    output logic [1:0]             o_talk_state,
    output logic                   o_screen_changed,
    output logic                   o_rec_changed,
    output logic                   o_talk_changed,
    output logic [TIME_W-1:0]      o_elapsed_ms,
    // Configuration port
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [APB_ADDR_W-1:0]  paddr,
    input  wire  [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

`include "record_talk_screen_controller_top_assert.svh"

    // Timeout registers.
    logic [TIME_W-1:0] r_screen_timeout;
    logic [TIME_W-1:0] r_sent_hold;
    logic [TIME_W-1:0] r_sending_tmo;
    logic [TIME_W-1:0] r_talk_ready_tmo;

    // Controller state and its next values.
    logic              r_screen_is_on,  n_screen_is_on;
    t_rec_phase        r_rec_phase,     n_rec_phase;
    t_talk_phase       r_talk_phase,    n_talk_phase;
    logic [TIME_W-1:0] r_last_activity, n_last_activity;
    logic [TIME_W-1:0] r_record_start,  n_record_start;
    logic [TIME_W-1:0] r_frozen_dur,    n_frozen_dur;
    logic [TIME_W-1:0] r_sending_start, n_sending_start;
    logic [TIME_W-1:0] r_sent_time,     n_sent_time;
    logic [TIME_W-1:0] r_connect_start, n_connect_start;

    // Input register.
    logic              r_in_valid;
    logic [2:0]        r_in_opcode;
    logic [TIME_W-1:0] r_in_now;
    logic [1:0]        r_in_target;

    // Output register.
    logic              r_out_valid;
    logic              r_out_accepted;
    logic              r_out_screen_on;
    t_rec_phase        r_out_rec_state;
    t_talk_phase       r_out_talk_state;
    logic              r_out_screen_changed;
    logic              r_out_rec_changed;
    logic              r_out_talk_changed;
    logic [TIME_W-1:0] r_out_elapsed;

    logic              advance;
    logic              cfg_write;
    logic              n_accepted;
    logic [TIME_W-1:0] n_elapsed;

    // Elapsed times since each stored timestamp, modulo 2^32.
    logic [TIME_W-1:0] since_sent;
    logic [TIME_W-1:0] since_sending;
    logic [TIME_W-1:0] since_connect;
    logic [TIME_W-1:0] since_activity;
    logic [TIME_W-1:0] since_record;
    logic              sent_expired;
    logic              sending_expired;
    logic              connect_expired;
    logic              talk_move_ok;

    // The output register is free when empty or being read this cycle.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb begin
        unique case (paddr[3:2])
            REG_SCREEN_TIMEOUT: prdata = r_screen_timeout;
            REG_SENT_HOLD:      prdata = r_sent_hold;
            REG_SENDING_TMO:    prdata = r_sending_tmo;
            REG_TALK_READY_TMO: prdata = r_talk_ready_tmo;
            default:            prdata = '0;
        endcase
    end

    assign since_sent     = r_in_now - r_sent_time;
    assign since_sending  = r_in_now - r_sending_start;
    assign since_connect  = r_in_now - r_connect_start;
    assign since_activity = r_in_now - r_last_activity;
    assign since_record   = r_in_now - r_record_start;

    assign sent_expired    = (r_rec_phase == REC_SENT) && (since_sent >= r_sent_hold);
    assign sending_expired = (r_rec_phase == REC_SENDING) && (since_sending >= r_sending_tmo);
    assign connect_expired = (r_talk_phase == TALK_CONNECTING)
                             && (since_connect >= r_talk_ready_tmo);

    // Legal talk moves; an equal or unknown target never matches.
    assign talk_move_ok =
        ((r_talk_phase == TALK_OFF) && (r_in_target == TALK_CONNECTING)) ||
        ((r_talk_phase == TALK_CONNECTING) &&
         ((r_in_target == TALK_ACTIVE) || (r_in_target == TALK_OFF))) ||
        ((r_talk_phase == TALK_ACTIVE) && (r_in_target == TALK_OFF));

    always_comb begin
        n_screen_is_on  = r_screen_is_on;
        n_rec_phase     = r_rec_phase;
        n_talk_phase    = r_talk_phase;
        n_last_activity = r_last_activity;
        n_record_start  = r_record_start;
        n_frozen_dur    = r_frozen_dur;
        n_sending_start = r_sending_start;
        n_sent_time     = r_sent_time;
        n_connect_start = r_connect_start;
        n_accepted      = 1'b0;

        unique case (r_in_opcode)
            OP_TICK: begin
                n_accepted = 1'b1;
                if (sent_expired || sending_expired) begin
                    n_rec_phase = REC_IDLE;
                end
                // A Connecting timeout also counts as activity, so the screen
                // check then sees zero idle time.
                if (connect_expired) begin
                    n_talk_phase    = TALK_OFF;
                    n_last_activity = r_in_now;
                end
                if (r_screen_is_on && (n_rec_phase == REC_IDLE)) begin
                    if (connect_expired ? (r_screen_timeout == '0)
                                        : (since_activity >= r_screen_timeout)) begin
                        n_screen_is_on = 1'b0;
                    end
                end
            end
            OP_ACTIVITY: begin
                n_accepted      = 1'b1;
                n_last_activity = r_in_now;
            end
            OP_START: begin
                if ((r_rec_phase != REC_RECORDING) && (r_talk_phase == TALK_OFF)) begin
                    n_accepted      = 1'b1;
                    n_record_start  = r_in_now;
                    n_frozen_dur    = '0;
                    n_last_activity = r_in_now;
                    n_screen_is_on  = 1'b1;
                    n_rec_phase     = REC_RECORDING;
                end
            end
            OP_STOP_SEND: begin
                if (r_rec_phase == REC_RECORDING) begin
                    n_accepted      = 1'b1;
                    n_frozen_dur    = since_record;
                    n_sending_start = r_in_now;
                    n_rec_phase     = REC_SENDING;
                end
            end
            OP_CANCEL: begin
                if (r_rec_phase == REC_RECORDING) begin
                    n_accepted   = 1'b1;
                    n_frozen_dur = '0;
                    n_rec_phase  = REC_IDLE;
                end
            end
            OP_RECEIPT: begin
                if (r_rec_phase == REC_SENDING) begin
                    n_accepted  = 1'b1;
                    n_sent_time = r_in_now;
                    n_rec_phase = REC_SENT;
                end
            end
            OP_ERROR: begin
                if (r_rec_phase == REC_SENDING) begin
                    n_accepted  = 1'b1;
                    n_rec_phase = REC_IDLE;
                end
            end
            OP_SET_TALK: begin
                if (talk_move_ok) begin
                    n_accepted      = 1'b1;
                    n_last_activity = r_in_now;
                    n_talk_phase    = t_talk_phase'(r_in_target);
                    if (r_in_target == TALK_CONNECTING) begin
                        n_connect_start = r_in_now;
                    end
                    if (r_in_target != TALK_OFF) begin
                        n_screen_is_on = 1'b1;
                    end
                end
            end
            default: begin
                n_accepted = 1'b0;
            end
        endcase

        // Live time while recording, else the frozen duration.
        n_elapsed = (n_rec_phase == REC_RECORDING) ? (r_in_now - n_record_start)
                                                   : n_frozen_dur;
    end

    // Control, state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_screen_timeout <= RST_SCREEN_TIMEOUT;
            r_sent_hold      <= RST_SENT_HOLD;
            r_sending_tmo    <= RST_SENDING_TMO;
            r_talk_ready_tmo <= RST_TALK_READY_TMO;
            r_screen_is_on   <= 1'b1;
            r_rec_phase      <= REC_IDLE;
            r_talk_phase     <= TALK_OFF;
            r_last_activity  <= '0;
            r_record_start   <= '0;
            r_frozen_dur     <= '0;
            r_sending_start  <= '0;
            r_sent_time      <= '0;
            r_connect_start  <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_write) begin
                unique case (paddr[3:2])
                    REG_SCREEN_TIMEOUT: r_screen_timeout <= pwdata;
                    REG_SENT_HOLD:      r_sent_hold      <= pwdata;
                    REG_SENDING_TMO:    r_sending_tmo    <= pwdata;
                    REG_TALK_READY_TMO: r_talk_ready_tmo <= pwdata;
                    default:            r_screen_timeout <= r_screen_timeout;
                endcase
            end
            if (advance) begin
                r_screen_is_on  <= n_screen_is_on;
                r_rec_phase     <= n_rec_phase;
                r_talk_phase    <= n_talk_phase;
                r_last_activity <= n_last_activity;
                r_record_start  <= n_record_start;
                r_frozen_dur    <= n_frozen_dur;
                r_sending_start <= n_sending_start;
                r_sent_time     <= n_sent_time;
                r_connect_start <= n_connect_start;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_opcode <= i_opcode;
            r_in_now    <= i_now_ms;
            r_in_target <= i_talk_target;
        end
        if (advance) begin
            r_out_accepted       <= n_accepted;
            r_out_screen_on      <= n_screen_is_on;
            r_out_rec_state      <= n_rec_phase;
            r_out_talk_state     <= n_talk_phase;
            r_out_screen_changed <= n_screen_is_on != r_screen_is_on;
            r_out_rec_changed    <= n_rec_phase != r_rec_phase;
            r_out_talk_changed   <= n_talk_phase != r_talk_phase;
            r_out_elapsed        <= n_elapsed;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_out_accepted;
    assign o_screen_on      = r_out_screen_on;
    assign o_rec_state      = r_out_rec_state;
    assign o_talk_state     = r_out_talk_state;
    assign o_screen_changed = r_out_screen_changed;
    assign o_rec_changed    = r_out_rec_changed;
    assign o_talk_changed   = r_out_talk_changed;
    assign o_elapsed_ms     = r_out_elapsed;

    // The screen can only go dark while recording is idle.
    `RTSC_ASSERT_NOW(a_busy_screen_on, i_clk, i_rst_n,
        r_rec_phase != REC_IDLE, r_screen_is_on)
    // An evaluated word always lands in the output register.
    `RTSC_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n,
        advance, r_out_valid)
    // The recording change flag matches the state it was derived from.
    `RTSC_ASSERT_NEXT(a_rec_flag, i_clk, i_rst_n,
        advance, r_out_rec_changed == (r_out_rec_state != $past(r_rec_phase)))
    // An accepted start always reports recording with the screen on.
    `RTSC_ASSERT_NEXT(a_start_records, i_clk, i_rst_n,
        advance && n_accepted && (r_in_opcode == OP_START),
        (r_out_rec_state == REC_RECORDING) && r_out_screen_on && (r_out_elapsed == '0))

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record/talk/screen controller testbench
// Sends timestamped events through the event channel and checks every
// result word against a predictor of the screen, recording and talk phases,
// under several timeout settings and with random stalls on both channels.
// ----------------------------------------------------------------------------

module testbench
    import rtsc_pkg::*;
;

    // One event word as it enters the block.
    typedef struct packed {
        logic [2:0]        op;
        logic [TIME_W-1:0] now;
        logic [1:0]        goal;
    } event_word_t;

    // One result word as it leaves the block.
    typedef struct packed {
        logic              accepted;
        logic              screen_on;
        logic [1:0]        rec_state;
        logic [1:0]        talk_state;
        logic              screen_changed;
        logic              rec_changed;
        logic              talk_changed;
        logic [TIME_W-1:0] elapsed_ms;
    } status_word_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals that drive the block. Every input starts
    // at a known value, with reset asserted.
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic              in_valid  = 1'b0;
    logic              out_ready = 1'b0;
    event_word_t       cur_word  = '0;

    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic              o_in_ready;
    logic              o_out_valid;
    logic              o_accepted;
    logic              o_screen_on;
    logic [1:0]        o_rec_state;
    logic [1:0]        o_talk_state;
    logic              o_screen_changed;
    logic              o_rec_changed;
    logic              o_talk_changed;
    logic [TIME_W-1:0] o_elapsed_ms;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    record_talk_screen_controller_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_opcode         (cur_word.op),
        .i_now_ms         (cur_word.now),
        .i_talk_target    (cur_word.goal),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_accepted       (o_accepted),
        .o_screen_on      (o_screen_on),
        .o_rec_state      (o_rec_state),
        .o_talk_state     (o_talk_state),
        .o_screen_changed (o_screen_changed),
        .o_rec_changed    (o_rec_changed),
        .o_talk_changed   (o_talk_changed),
        .o_elapsed_ms     (o_elapsed_ms),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // ------------------------------------------------------------------------
    // Predictor state. The timeouts mirror what has been written over the
    // configuration port; the rest mirrors the block's phases and stamps.
    // ------------------------------------------------------------------------
    logic [TIME_W-1:0] tmo_screen;
    logic [TIME_W-1:0] hold_sent;
    logic [TIME_W-1:0] tmo_sending;
    logic [TIME_W-1:0] tmo_talk;

    logic              scr_on;
    t_rec_phase        rec_ph;
    t_talk_phase       talk_ph;
    logic [TIME_W-1:0] t_activity;
    logic [TIME_W-1:0] t_rec_start;
    logic [TIME_W-1:0] frozen_ms;
    logic [TIME_W-1:0] t_send_start;
    logic [TIME_W-1:0] t_sent;
    logic [TIME_W-1:0] t_connect;

    // Words waiting to be sent, and result words waiting to be seen.
    event_word_t  event_backlog[$];
    status_word_t awaited_status[$];

    bit          in_busy = 1'b0;   // a word is on the event channel
    bit          calm    = 1'b0;   // no idling on either side while set
    int unsigned produced   = 0;   // words generated so far
    int unsigned mismatches = 0;
    logic [TIME_W-1:0] stamp = '0; // running millisecond clock of the stimulus

    // A talk request. Only off to connecting, connecting to active or off,
    // and active to off are legal; anything else, including an equal target
    // or the unused code, leaves every piece of state alone.
    function automatic bit talk_move(input logic [1:0] goal, input logic [TIME_W-1:0] now);
        bit legal;
        if (talk_ph == goal)
            return 1'b0;
        legal = (talk_ph == TALK_OFF        && goal == TALK_CONNECTING) ||
                (talk_ph == TALK_CONNECTING && (goal == TALK_ACTIVE || goal == TALK_OFF)) ||
                (talk_ph == TALK_ACTIVE     && goal == TALK_OFF);
        if (!legal)
            return 1'b0;
        if (goal == TALK_CONNECTING)
            t_connect = now;
        t_activity = now;
        if (goal != TALK_OFF)
            scr_on = 1'b1;
        talk_ph = t_talk_phase'(goal);
        return 1'b1;
    endfunction

    // Applies one event to the predictor state and returns the result word
    // the block must produce for it. Time differences wrap at 32 bits.
    function automatic status_word_t advance_controller(input event_word_t ev);
        status_word_t res;
        logic         scr0;
        t_rec_phase   rec0;
        t_talk_phase  talk0;
        logic         acc;
        scr0  = scr_on;
        rec0  = rec_ph;
        talk0 = talk_ph;
        acc   = 1'b0;
        case (ev.op)
            OP_TICK: begin
                // The four timeouts run in order, each seeing the one before.
                acc = 1'b1;
                if (rec_ph == REC_SENT && ev.now - t_sent >= hold_sent)
                    rec_ph = REC_IDLE;
                if (rec_ph == REC_SENDING && ev.now - t_send_start >= tmo_sending)
                    rec_ph = REC_IDLE;
                if (talk_ph == TALK_CONNECTING && ev.now - t_connect >= tmo_talk)
                    void'(talk_move(TALK_OFF, ev.now));
                if (scr_on && rec_ph == REC_IDLE && ev.now - t_activity >= tmo_screen)
                    scr_on = 1'b0;
            end
            OP_ACTIVITY: begin
                acc = 1'b1;
                t_activity = ev.now;
            end
            OP_START: begin
                if (rec_ph != REC_RECORDING && talk_ph == TALK_OFF) begin
                    t_rec_start = ev.now;
                    frozen_ms   = '0;
                    t_activity  = ev.now;
                    scr_on      = 1'b1;
                    rec_ph      = REC_RECORDING;
                    acc         = 1'b1;
                end
            end
            OP_STOP_SEND: begin
                if (rec_ph == REC_RECORDING) begin
                    frozen_ms    = ev.now - t_rec_start;
                    t_send_start = ev.now;
                    rec_ph       = REC_SENDING;
                    acc          = 1'b1;
                end
            end
            OP_CANCEL: begin
                if (rec_ph == REC_RECORDING) begin
                    frozen_ms = '0;
                    rec_ph    = REC_IDLE;
                    acc       = 1'b1;
                end
            end
            OP_RECEIPT: begin
                if (rec_ph == REC_SENDING) begin
                    t_sent = ev.now;
                    rec_ph = REC_SENT;
                    acc    = 1'b1;
                end
            end
            OP_ERROR: begin
                if (rec_ph == REC_SENDING) begin
                    rec_ph = REC_IDLE;
                    acc    = 1'b1;
                end
            end
            default: begin
                acc = talk_move(ev.goal, ev.now);
            end
        endcase
        res.accepted       = acc;
        res.screen_on      = scr_on;
        res.rec_state      = rec_ph;
        res.talk_state     = talk_ph;
        res.screen_changed = (scr_on != scr0);
        res.rec_changed    = (rec_ph != rec0);
        res.talk_changed   = (talk_ph != talk0);
        // Live time while recording, otherwise the duration frozen at stop.
        res.elapsed_ms     = (rec_ph == REC_RECORDING) ? ev.now - t_rec_start : frozen_ms;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Event driver. A word is picked from the backlog at a falling edge and
    // held until the rising edge that accepts it. The valid line is only
    // lowered in reset, when no word follows, or when the sender chooses to idle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && o_in_ready) begin
            awaited_status.push_back(advance_controller(cur_word));
            in_busy = 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!in_busy) begin
            if (i_rst_n && event_backlog.size() != 0 && (calm || $urandom_range(99) >= 34)) begin
                cur_word <= event_backlog.pop_front();
                in_valid <= 1'b1;
                in_busy = 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor. The receiver stalls at random, and every word it takes
    // is compared field by field with the oldest expectation.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        out_ready <= i_rst_n && (calm || $urandom_range(99) >= 34);
    end

    always @(posedge i_clk) begin : result_monitor
        status_word_t want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (awaited_status.size() == 0) begin
                if (mismatches < 10)
                    $display("ERROR: result word arrived with no event outstanding");
                mismatches++;
            end else begin
                want = awaited_status.pop_front();
                if (want.accepted       !== o_accepted       ||
                    want.screen_on      !== o_screen_on      ||
                    want.rec_state      !== o_rec_state      ||
                    want.talk_state     !== o_talk_state     ||
                    want.screen_changed !== o_screen_changed ||
                    want.rec_changed    !== o_rec_changed    ||
                    want.talk_changed   !== o_talk_changed   ||
                    want.elapsed_ms     !== o_elapsed_ms) begin
                    if (mismatches < 10) begin
                        $display("ERROR: result mismatch at %0t", $time);
                        $display("  expected acc=%0d scr=%0d rec=%0d talk=%0d chg=%b%b%b el=%0d",
                                 want.accepted, want.screen_on, want.rec_state,
                                 want.talk_state, want.screen_changed, want.rec_changed,
                                 want.talk_changed, want.elapsed_ms);
                        $display("  actual   acc=%0d scr=%0d rec=%0d talk=%0d chg=%b%b%b el=%0d",
                                 o_accepted, o_screen_on, o_rec_state, o_talk_state,
                                 o_screen_changed, o_rec_changed, o_talk_changed,
                                 o_elapsed_ms);
                    end
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic push_event(input logic [2:0] op, input logic [TIME_W-1:0] now,
                              input logic [1:0] goal);
        event_backlog.push_back('{op: op, now: now, goal: goal});
        produced++;
    endtask

    // Moves the stimulus clock forward by a gap that is usually short against
    // the timeouts, sometimes long enough to trip them, and now and then so
    // large that the counter wraps, then queues one word at the new time.
    task automatic emit(input logic [2:0] op, input logic [1:0] goal);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45)
            stamp += $urandom_range(400);
        else if (r < 80)
            stamp += $urandom_range(3000, 400);
        else if (r < 96)
            stamp += $urandom_range(12000, 3000);
        else
            stamp += $urandom;
        push_event(op, stamp, goal);
    endtask

    // A tick or an activity word; either may come at any point of a session.
    task automatic emit_filler();
        emit(($urandom_range(3) == 0) ? OP_ACTIVITY : OP_TICK, 2'($urandom_range(3)));
    endtask

    // Most traffic follows the device's real flows: record and send, record
    // and cancel, or a talk session. The rest is noise of any kind.
    task automatic gen_session();
        int unsigned kind;
        int unsigned k;
        kind = $urandom_range(99);
        if (kind < 40) begin
            emit(OP_START, 2'($urandom_range(3)));
            repeat ($urandom_range(3)) emit_filler();
            emit(OP_STOP_SEND, 2'($urandom_range(3)));
            repeat ($urandom_range(3)) emit(OP_TICK, 2'($urandom_range(3)));
            k = $urandom_range(9);
            if (k < 6)
                emit(OP_RECEIPT, 2'($urandom_range(3)));
            else if (k < 8)
                emit(OP_ERROR, 2'($urandom_range(3)));
            repeat ($urandom_range(4)) emit_filler();
        end else if (kind < 55) begin
            emit(OP_START, 2'($urandom_range(3)));
            repeat ($urandom_range(3)) emit_filler();
            emit(OP_CANCEL, 2'($urandom_range(3)));
        end else if (kind < 80) begin
            emit(OP_SET_TALK, TALK_CONNECTING);
            repeat ($urandom_range(3)) emit_filler();
            k = $urandom_range(9);
            if (k < 6) begin
                emit(OP_SET_TALK, TALK_ACTIVE);
                repeat ($urandom_range(3)) emit_filler();
            end
            if (k != 9)
                emit(OP_SET_TALK, TALK_OFF);
        end else begin
            repeat ($urandom_range(4, 1))
                emit(3'($urandom_range(7)), 2'($urandom_range(3)));
        end
    endtask

    task automatic gen_traffic(input int unsigned count);
        int unsigned goal_count;
        goal_count = produced + count;
        while (produced < goal_count)
            gen_session();
    endtask

    // Returns at a falling edge once every queued word has been accepted and
    // every expected result word has been seen.
    task automatic wait_drained();
        while (event_backlog.size() != 0 || in_busy || awaited_status.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // One configuration write: a setup phase, then an access phase that ends
    // at the rising edge where pready is high. Starts and ends at a falling
    // edge.
    task automatic cfg_write(input logic [1:0] idx, input logic [TIME_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SCREEN_TIMEOUT: tmo_screen  = value;
            REG_SENT_HOLD:      hold_sent   = value;
            REG_SENDING_TMO:    tmo_sending = value;
            default:            tmo_talk    = value;
        endcase
    endtask

    task automatic cfg_all(input logic [TIME_W-1:0] scr, input logic [TIME_W-1:0] hold,
                           input logic [TIME_W-1:0] snd, input logic [TIME_W-1:0] talk);
        cfg_write(REG_SCREEN_TIMEOUT, scr);
        cfg_write(REG_SENT_HOLD, hold);
        cfg_write(REG_SENDING_TMO, snd);
        cfg_write(REG_TALK_READY_TMO, talk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        // The block comes out of reset as if begun at time zero, with the
        // default timeouts loaded.
        tmo_screen   = RST_SCREEN_TIMEOUT;
        hold_sent    = RST_SENT_HOLD;
        tmo_sending  = RST_SENDING_TMO;
        tmo_talk     = RST_TALK_READY_TMO;
        scr_on       = 1'b1;
        rec_ph       = REC_IDLE;
        talk_ph      = TALK_OFF;
        t_activity   = '0;
        t_rec_start  = '0;
        frozen_ms    = '0;
        t_send_start = '0;
        t_sent       = '0;
        t_connect    = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk through the flows with the default timeouts.
        push_event(OP_TICK,      32'd0,     2'd0);
        push_event(OP_TICK,      32'd10000, 2'd0);   // screen goes dark
        push_event(OP_ACTIVITY,  32'd10001, 2'd0);
        push_event(OP_START,     32'd10010, 2'd3);
        push_event(OP_START,     32'd10020, 2'd0);   // already recording
        push_event(OP_TICK,      32'd30000, 2'd0);   // no auto-off while recording
        push_event(OP_STOP_SEND, 32'd30500, 2'd0);
        push_event(OP_CANCEL,    32'd30600, 2'd0);   // wrong phase
        push_event(OP_TICK,      32'd38500, 2'd0);   // sending gives up
        push_event(OP_START,     32'd38700, 2'd0);
        push_event(OP_CANCEL,    32'd38800, 2'd0);
        push_event(OP_START,     32'd39000, 2'd0);
        push_event(OP_STOP_SEND, 32'd39100, 2'd0);
        push_event(OP_ERROR,     32'd39200, 2'd0);
        push_event(OP_START,     32'd39300, 2'd0);
        push_event(OP_STOP_SEND, 32'd39400, 2'd0);
        push_event(OP_RECEIPT,   32'd39500, 2'd0);
        push_event(OP_TICK,      32'd40999, 2'd0);   // one short of the hold
        push_event(OP_TICK,      32'd41000, 2'd0);   // hold over
        push_event(OP_SET_TALK,  32'd41100, 2'd3);   // unused target code
        push_event(OP_SET_TALK,  32'd41120, TALK_OFF);
        push_event(OP_SET_TALK,  32'd41150, TALK_ACTIVE);
        push_event(OP_SET_TALK,  32'd41200, TALK_CONNECTING);
        push_event(OP_START,     32'd41300, 2'd0);   // talk is busy
        push_event(OP_SET_TALK,  32'd41400, TALK_ACTIVE);
        push_event(OP_SET_TALK,  32'd41450, TALK_CONNECTING);
        push_event(OP_SET_TALK,  32'd41500, TALK_OFF);
        push_event(OP_SET_TALK,  32'd42000, TALK_CONNECTING);
        push_event(OP_TICK,      32'd52000, 2'd0);   // connecting times out
        push_event(OP_TICK,      32'd62000, 2'd0);
        stamp = 32'd62000;
        gen_traffic(450);
        wait_drained();

        // All timeouts zero: every guard fires on the first tick. The session
        // ends by clearing recording and talk so the next phase starts idle.
        cfg_all(32'd0, 32'd0, 32'd0, 32'd0);
        gen_traffic(200);
        emit(OP_CANCEL, 2'd0);
        emit(OP_TICK, 2'd0);
        emit(OP_SET_TALK, TALK_OFF);
        wait_drained();

        // All timeouts at the top of the range: only a gap of all ones can
        // reach them, which a stamp one behind the reference gives.
        cfg_all('1, '1, '1, '1);
        stamp += 32'd100;
        push_event(OP_START,     stamp,         2'd0);
        push_event(OP_CANCEL,    stamp,         2'd0);
        push_event(OP_ACTIVITY,  stamp,         2'd0);
        push_event(OP_TICK,      stamp - 32'd1, 2'd0);
        push_event(OP_START,     stamp + 32'd5, 2'd0);
        push_event(OP_STOP_SEND, stamp + 32'd10, 2'd0);
        push_event(OP_TICK,      stamp + 32'd9, 2'd0);
        stamp += 32'd10;
        gen_traffic(200);
        wait_drained();

        // Short random timeouts, back to back on both channels, starting from
        // a random point of the millisecond counter.
        cfg_all($urandom_range(6000), $urandom_range(6000),
                $urandom_range(6000), $urandom_range(6000));
        calm  = 1'b1;
        stamp = $urandom;
        gen_traffic(300);
        wait_drained();
        calm = 1'b0;

        // Wider random timeouts with stalls again.
        cfg_all($urandom_range(20000), $urandom_range(20000),
                $urandom_range(20000), $urandom_range(20000));
        gen_traffic(400);
        wait_drained();

        // Let the pipeline settle; a stray word here is still caught.
        repeat (4) @(posedge i_clk);
        mismatches += awaited_status.size();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: a correct run ends far sooner than this.
    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
